>>> sv/psct_pkg.sv
package psct_pkg;

   localparam int MAX_PROCESSES_DEF = 64;
   localparam int NUM_SYSCALLS_DEF  = 512;

   localparam int PID_W      = 22;
   localparam int SYSCALL_W  = 9;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 6;
   localparam int COUNT_W    = 32;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam logic FUNC_COUNT   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_COUNTED   = 3'd0,
      ST_ALLOCATED = 3'd1,
      ST_FULL      = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

   typedef struct packed {
      logic                 func;
      logic [PID_W-1:0]     pid;
      logic [SYSCALL_W-1:0] sys_num;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [COUNT_W-1:0]    count;
   } rsp_type;

   typedef enum logic {
      FE_IDLE,
      FE_LOOKUP
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_INIT,
      BE_IDLE,
      BE_READ,
      BE_CLEAR,
      BE_RESULT
   } be_state_type;

endpackage

>>> sv/psct_fifo.sv
module psct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/psct_front.sv
module psct_front #(
   parameter int  MAX_PROCESSES = psct_pkg::MAX_PROCESSES_DEF,
   parameter int  NUM_SYSCALLS  = psct_pkg::NUM_SYSCALLS_DEF,
   localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   localparam int SYS_W  = (NUM_SYSCALLS > 1) ? $clog2(NUM_SYSCALLS) : 1,
   localparam int CMD_W  = psct_pkg::STATUS_W + SLOT_W + SYS_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  psct_pkg::req_type req_data,
   output logic              busy,
   output logic              cmd_push,
   output logic [CMD_W-1:0]  cmd_data,
   input  logic              cmd_full
);

   import psct_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [SYS_W-1:0]  sys;
   } cmd_type;

   fe_state_type             state_ff, state_in;
   req_type                  item_ff;
   logic [MAX_PROCESSES-1:0] match_ff, match_in;
   logic [MAX_PROCESSES-1:0] free_ff;
   logic [MAX_PROCESSES-1:0] valid_ff, valid_in;
   logic [PID_W-1:0]         pid_ff [MAX_PROCESSES];
   logic                     pid_we;
   logic [SLOT_W-1:0]        hit_idx, free_idx;
   logic                     hit, any_free;
   cmd_type                  cmd;

   always_comb begin
      for (int k = 0; k < MAX_PROCESSES; k++) begin
         match_in[k] = valid_ff[k] && (pid_ff[k] == req_data.pid);
      end
   end

   // Lowest index wins for both the pid match and the free slot search.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int k = MAX_PROCESSES - 1; k >= 0; k--) begin
         if (match_ff[k]) begin
            hit_idx = SLOT_W'(k);
         end
         if (free_ff[k]) begin
            free_idx = SLOT_W'(k);
         end
      end
   end

   assign hit      = |match_ff;
   assign any_free = |free_ff;
   assign busy     = (state_ff != FE_IDLE);
   assign cmd_data = cmd;

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      pid_we     = 1'b0;
      cmd_push   = 1'b0;
      cmd.status = ST_IGNORED;
      cmd.slot   = '0;
      cmd.sys    = SYS_W'(item_ff.sys_num);
      case (state_ff)
         FE_IDLE: begin
            if (accept) begin
               state_in = FE_LOOKUP;
            end
         end
         FE_LOOKUP: begin
            if (item_ff.func == FUNC_RELEASE) begin
               if (hit) begin
                  cmd.status = ST_RELEASED;
                  cmd.slot   = hit_idx;
               end
            end else if (int'(item_ff.sys_num) < NUM_SYSCALLS) begin
               if (hit) begin
                  cmd.status = ST_COUNTED;
                  cmd.slot   = hit_idx;
               end else if (any_free) begin
                  cmd.status = ST_ALLOCATED;
                  cmd.slot   = free_idx;
               end else begin
                  cmd.status = ST_FULL;
               end
            end
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = FE_IDLE;
               if (cmd.status == ST_RELEASED) begin
                  valid_in[hit_idx] = 1'b0;
               end else if (cmd.status == ST_ALLOCATED) begin
                  valid_in[free_idx] = 1'b1;
                  pid_we             = 1'b1;
               end
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (state_ff == FE_IDLE)) begin
         item_ff  <= req_data;
         match_ff <= match_in;
         free_ff  <= ~valid_ff;
      end
      if (pid_we) begin
         pid_ff[free_idx] <= item_ff.pid;
      end
   end

endmodule

>>> sv/psct_back.sv
module psct_back #(
   parameter int  MAX_PROCESSES = psct_pkg::MAX_PROCESSES_DEF,
   parameter int  NUM_SYSCALLS  = psct_pkg::NUM_SYSCALLS_DEF,
   localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   localparam int SYS_W  = (NUM_SYSCALLS > 1) ? $clog2(NUM_SYSCALLS) : 1,
   localparam int CMD_W  = psct_pkg::STATUS_W + SLOT_W + SYS_W
) (
   input  logic              clock,
   input  logic              reset,
   output logic              init_busy,
   input  logic              cmd_empty,
   input  logic [CMD_W-1:0]  cmd_data,
   output logic              cmd_pop,
   output logic              rsp_push,
   output psct_pkg::rsp_type rsp_item,
   input  logic              rsp_full
);

   import psct_pkg::*;

   localparam int ADDR_W = SLOT_W + SYS_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [SYS_W-1:0]  sys;
   } cmd_type;

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   be_state_type       state_ff, state_in;
   cmd_type            head;
   cmd_type            cmd_ff, cmd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  init_ff, init_in;
   logic [SYS_W-1:0]   row_ff, row_in;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [COUNT_W-1:0] wr_data, bumped;

   assign head      = cmd_data;
   assign rd_addr   = {head.slot, head.sys};
   assign init_busy = (state_ff == BE_INIT);
   assign bumped    = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + COUNT_W'(1);

   assign rsp_item.status = cmd_ff.status;
   assign rsp_item.slot   = SLOT_OUT_W'(cmd_ff.slot);
   assign rsp_item.count  = count_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      init_in  = init_ff;
      row_in   = row_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = {cmd_ff.slot, cmd_ff.sys};
      wr_data  = '0;
      case (state_ff)
         BE_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff;
            init_in = init_ff + ADDR_W'(1);
            if (init_ff == '1) begin
               state_in = BE_IDLE;
            end
         end
         BE_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = head;
               count_in = '0;
               case (head.status)
                  ST_COUNTED: begin
                     state_in = BE_READ;
                  end
                  ST_ALLOCATED: begin
                     // The row was already zeroed by the reset clear pass or when the slot was last freed.
                     wr_en    = 1'b1;
                     wr_addr  = rd_addr;
                     wr_data  = COUNT_W'(1);
                     count_in = COUNT_W'(1);
                     state_in = BE_RESULT;
                  end
                  ST_RELEASED: begin
                     row_in   = '0;
                     state_in = BE_CLEAR;
                  end
                  default: begin
                     state_in = BE_RESULT;
                  end
               endcase
            end
         end
         BE_READ: begin
            wr_en    = 1'b1;
            wr_data  = bumped;
            count_in = bumped;
            state_in = BE_RESULT;
         end
         BE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = {cmd_ff.slot, row_ff};
            row_in  = row_ff + SYS_W'(1);
            if (row_ff == SYS_W'(NUM_SYSCALLS - 1)) begin
               state_in = BE_RESULT;
            end
         end
         BE_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BE_IDLE;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_INIT;
         init_ff  <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> sv/process_syscall_counter_table_unit.sv
// Flow: an accepted beat is looked up in the front, queued as a command, then handled
// by the back; an allocate, drop or ignore beat goes straight to its result, a count
// reads and then writes its counter word, and a release sweeps its counter row.
// The front takes no new beat until it has queued the command for the last one; the back
// handles one command at a time and stalls while the result queue is full.
// Reset: all slots free; the counter memory is then zeroed one word a cycle over
// 2**(clog2(MAX_PROCESSES)+clog2(NUM_SYSCALLS)) words (32768 by default), full held high.
module process_syscall_counter_table_unit #(
   parameter int MAX_PROCESSES = psct_pkg::MAX_PROCESSES_DEF,
   parameter int NUM_SYSCALLS  = psct_pkg::NUM_SYSCALLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  psct_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output psct_pkg::rsp_type rsp_data
);

   import psct_pkg::*;

   localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int SYS_W  = (NUM_SYSCALLS > 1) ? $clog2(NUM_SYSCALLS) : 1;
   localparam int CMD_W  = STATUS_W + SLOT_W + SYS_W;
   localparam int RSP_W  = $bits(rsp_type);

   logic             fe_busy, init_busy, accept;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_wr, cmd_rd;
   logic             rsp_push, rsp_full;
   rsp_type          rsp_item;
   logic [RSP_W-1:0] rsp_vec;

   assign full     = fe_busy || init_busy;
   assign accept   = push && !full;
   assign rsp_data = rsp_vec;

   psct_front #(
      .MAX_PROCESSES(MAX_PROCESSES),
      .NUM_SYSCALLS (NUM_SYSCALLS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_data(req_data),
      .busy    (fe_busy),
      .cmd_push(cmd_push),
      .cmd_data(cmd_wr),
      .cmd_full(cmd_full)
   );

   psct_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_data(cmd_wr),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_data(cmd_rd),
      .empty  (cmd_empty)
   );

   psct_back #(
      .MAX_PROCESSES(MAX_PROCESSES),
      .NUM_SYSCALLS (NUM_SYSCALLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .init_busy(init_busy),
      .cmd_empty(cmd_empty),
      .cmd_data (cmd_rd),
      .cmd_pop  (cmd_pop),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .rsp_full (rsp_full)
   );

   psct_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_item),
      .full   (rsp_full),
      .pop    (pop),
      .rd_data(rsp_vec),
      .empty  (empty)
   );

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> empty)
      else $error("result offered during the counter clear pass");

   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("front took a new beat before finishing the last one");

   a_alloc_one: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.status == ST_ALLOCATED)) |-> (rsp_data.count == COUNT_W'(1)))
      else $error("new slot reported with a count other than one");

   a_noslot_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && ((rsp_data.status == ST_FULL) || (rsp_data.status == ST_IGNORED)))
      |-> ((rsp_data.slot == '0) && (rsp_data.count == '0)))
      else $error("dropped or ignored beat carries a slot or count");

endmodule
